FILE: hdl/cks_pkg.sv
// ----------------------------------------------------------------------------
// cks_pkg: shared types and constants for canonical_kmer_stream
// Word formats of the nucleotide and k-mer channels and register map codes.
// ----------------------------------------------------------------------------
package cks_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int KLEN_W = 6;

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_KMER_LENGTH = 1'b0,
		REG_INPUT_CODED = 1'b1
	} reg_idx_t;

	localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd31;
	localparam logic [1:0] COMP_XOR = 2'd2;

	typedef struct packed {
		logic [7:0] nucleotide;
		logic       first_of_read;
	} nuc_word_t;

	typedef struct packed {
		logic [63:0] canonical_kmer;
		logic [63:0] forward_kmer;
		logic [63:0] reverse_kmer;
	} kmer_word_t;

endpackage

FILE: hdl/canonical_kmer_stream.sv
// ----------------------------------------------------------------------------
// canonical_kmer_stream: rolling canonical k-mer of a nucleotide stream
// Each accepted nucleotide word's k-mer word is registered and appears in the next cycle.
// Throughput: one nucleotide per cycle; the shift/mask/compare logic feeds
// the output register directly and the input stalls only on a held result.
// Reset: rolling k-mers, fill count and valid clear, kmer_length returns to 31, letter mode; kmer word is not reset.
// ----------------------------------------------------------------------------
module canonical_kmer_stream #(
	parameter int MAX_K = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// nucleotide channel
	input  logic                          nuc_valid,
	output logic                          nuc_stall,
	input  cks_pkg::nuc_word_t            nuc,
	// k-mer channel
	output logic                          kmer_valid,
	input  logic                          kmer_stall,
	output cks_pkg::kmer_word_t           kmer,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cks_pkg::ADDR_W-1:0]    paddr,
	input  logic [cks_pkg::DATA_W-1:0]    pwdata,
	output logic [cks_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int KW = 2 * MAX_K;
	localparam int FW = $clog2(MAX_K + 1);
	localparam int CW = (FW > cks_pkg::KLEN_W) ? FW + 1 : cks_pkg::KLEN_W + 1;

	logic [cks_pkg::KLEN_W-1:0] klen_q;
	logic                       coded_q;
	logic [KW-1:0]              fwd_q;
	logic [KW-1:0]              rev_q;
	logic [FW-1:0]              fill_q;
	logic                       kmer_valid_q;
	cks_pkg::kmer_word_t        kmer_q;

	logic                       nuc_accept;
	logic                       cfg_write;
	cks_pkg::reg_idx_t          reg_idx;
	logic [cks_pkg::KLEN_W-1:0] k_eff;
	logic [1:0]                 code;
	logic [1:0]                 comp;
	logic [KW-1:0]              fwd_shift;
	logic [KW-1:0]              rev_shift;
	logic [KW-1:0]              fwd_next;
	logic [KW-1:0]              rev_next;
	logic [FW-1:0]              fill_next;
	logic                       emit;

	assign pready     = 1'b1;
	assign cfg_write  = psel & penable & pwrite;
	assign reg_idx    = cks_pkg::reg_idx_t'(paddr[2]);
	assign nuc_stall  = kmer_valid_q & kmer_stall;
	assign nuc_accept = nuc_valid & ~nuc_stall;
	assign kmer_valid = kmer_valid_q;
	assign kmer       = kmer_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q  <= cks_pkg::KLEN_RESET;
			coded_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				cks_pkg::REG_KMER_LENGTH: klen_q  <= pwdata[cks_pkg::KLEN_W-1:0];
				cks_pkg::REG_INPUT_CODED: coded_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			cks_pkg::REG_KMER_LENGTH: prdata = cks_pkg::DATA_W'(klen_q);
			cks_pkg::REG_INPUT_CODED: prdata = cks_pkg::DATA_W'(coded_q);
			default: prdata = '0;
		endcase
	end

	// clamp length to 1..MAX_K
	always_comb begin
		k_eff = klen_q;
		if (klen_q == '0)
			k_eff = cks_pkg::KLEN_W'(1);
		else if (klen_q > cks_pkg::KLEN_W'(MAX_K))
			k_eff = cks_pkg::KLEN_W'(MAX_K);
	end

	assign code = coded_q ? nuc.nucleotide[1:0] : nuc.nucleotide[2:1];
	assign comp = code ^ cks_pkg::COMP_XOR;

	// drop the old k-mer at the start of a read
	always_comb begin
		if (nuc.first_of_read) begin
			fwd_shift = KW'(code);
			rev_shift = '0;
		end else begin
			fwd_shift = {fwd_q[KW-3:0], code};
			rev_shift = {2'b00, rev_q[KW-1:2]};
		end
	end

	// per-position mask; complement is OR-ed in at position k-1
	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			if (cks_pkg::KLEN_W'(i) < k_eff)
				fwd_next[2*i +: 2] = fwd_shift[2*i +: 2];
			else
				fwd_next[2*i +: 2] = 2'b00;
			if (cks_pkg::KLEN_W'(i + 1) == k_eff)
				rev_next[2*i +: 2] = rev_shift[2*i +: 2] | comp;
			else if (cks_pkg::KLEN_W'(i + 1) < k_eff)
				rev_next[2*i +: 2] = rev_shift[2*i +: 2];
			else
				rev_next[2*i +: 2] = 2'b00;
		end
	end

	always_comb begin
		if (nuc.first_of_read)
			fill_next = FW'(1);
		else if (fill_q < FW'(MAX_K))
			fill_next = fill_q + FW'(1);
		else
			fill_next = fill_q;
	end

	assign emit = CW'(fill_next) >= CW'(k_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q        <= '0;
			rev_q        <= '0;
			fill_q       <= '0;
			kmer_valid_q <= 1'b0;
		end else if (nuc_accept) begin
			fwd_q        <= fwd_next;
			rev_q        <= rev_next;
			fill_q       <= fill_next;
			kmer_valid_q <= emit;
		end else if (!kmer_stall) begin
			kmer_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (nuc_accept) begin
			kmer_q.forward_kmer   <= 64'(fwd_next);
			kmer_q.reverse_kmer   <= 64'(rev_next);
			kmer_q.canonical_kmer <= (fwd_next < rev_next) ? 64'(fwd_next) : 64'(rev_next);
		end
	end

endmodule
